// File: design/pcr_pkg.sv
`default_nettype none

package pcr_pkg;

   localparam int unsigned COORD_W    = 16;
   localparam int unsigned ANGLE_W    = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_IDX_W  = 3;

   localparam logic [ANGLE_W:0]   FULL_TURN = 17'd36000;
   localparam logic [COUNT_W-1:0] MISS_MAX  = 8'd255;

   localparam logic [CSR_DATA_W-1:0] XY_DEADBAND_RST      = 16'd10;
   localparam logic [CSR_DATA_W-1:0] ANGLE_DEADBAND_RST   = 16'd500;
   localparam logic [CSR_DATA_W-1:0] HEARTBEAT_PERIOD_RST = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] IDLE_DELAY_RST       = 16'd1000;
   localparam logic [COUNT_W-1:0]    LOST_LIMIT_RST       = 8'd10;
   localparam logic [CSR_DATA_W-1:0] BCAST_PERIOD_RST     = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_XY_DEADBAND      = 3'd0,
      CSR_ANGLE_DEADBAND   = 3'd1,
      CSR_HEARTBEAT_PERIOD = 3'd2,
      CSR_IDLE_DELAY       = 3'd3,
      CSR_LOST_LIMIT       = 3'd4,
      CSR_BCAST_PERIOD     = 3'd5,
      CSR_STAMPED_MODE     = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

// File: design/pose_change_reporter.sv
// An accepted item passes through the input register, then the result register,
// which loads only when empty or when its result is taken; rsp_ready low stalls it.
// Throughput: one item per cycle unless stalled; result refilled as it is taken.
// Reset (synchronous, active high): registers to defaults, deadband references,
// timers and miss count to zero, lifted status set, both stages empty.
`default_nettype none

module pose_change_reporter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic signed [pcr_pkg::COORD_W-1:0]   req_pos_x,
   input  wire logic signed [pcr_pkg::COORD_W-1:0]   req_pos_y,
   input  wire logic signed [pcr_pkg::ANGLE_W-1:0]   req_angle_cdeg,
   input  wire logic                                 req_off_ground,
   input  wire logic                                 req_decode_ok,
   input  wire logic        [pcr_pkg::TIME_W-1:0]    req_now_ms,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic                                 rsp_send_pose,
   output      logic                                 rsp_kidnap_event,
   output      logic                                 rsp_kidnap_now,
   output      logic                                 rsp_activity,
   output      logic signed [pcr_pkg::COORD_W-1:0]   rsp_out_x,
   output      logic signed [pcr_pkg::COORD_W-1:0]   rsp_out_y,
   output      logic        [pcr_pkg::ANGLE_W-1:0]   rsp_out_theta,
   output      logic        [pcr_pkg::TIME_W-1:0]    rsp_out_stamp,
   input  wire logic                                 csr_wr_en,
   input  wire logic        [pcr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [pcr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pcr_pkg::*;

   // configuration
   logic [CSR_DATA_W-1:0] xy_db_ff, ang_db_ff, hb_period_ff, idle_delay_ff, bc_period_ff;
   logic [COUNT_W-1:0]    lost_limit_ff;
   logic                  stamped_ff;

   // input stage
   logic                      in_valid_ff;
   logic signed [COORD_W-1:0] in_x_ff, in_y_ff;
   logic signed [ANGLE_W-1:0] in_ang_ff;
   logic                      in_off_ff, in_ok_ff;
   logic [TIME_W-1:0]         in_now_ff;

   // result stage
   logic                      out_valid_ff;
   logic                      out_send_ff, out_event_ff, out_lifted_ff, out_act_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff;
   logic [ANGLE_W-1:0]        out_theta_ff;
   logic [TIME_W-1:0]         out_stamp_ff;

   // tracking state
   logic signed [COORD_W-1:0] ref_x_ff, ref_y_ff, ref_x_in, ref_y_in;
   logic [ANGLE_W-1:0]        ref_theta_ff, ref_theta_in;
   logic                      lifted_ff, lifted_in, idle_ff, idle_in;
   logic [COUNT_W-1:0]        miss_ff, miss_in;
   logic [TIME_W-1:0]         last_change_ff, last_change_in;
   logic [TIME_W-1:0]         last_bcast_ff, last_bcast_in;
   logic [TIME_W-1:0]         good_stamp_ff, good_stamp_in;

   logic advance;

   // per-item logic
   logic signed [ANGLE_W:0]   neg_ang;
   logic [ANGLE_W-1:0]        theta;
   logic signed [COORD_W:0]   dx, dy;
   logic signed [ANGLE_W:0]   dt;
   logic [COORD_W-1:0]        adx, ady;
   logic [ANGLE_W-1:0]        adt;
   logic                      xs, ys, ts, same, pose_ok;
   logic [CSR_DATA_W-1:0]     hb;
   logic [TIME_W-1:0]         since_bcast, since_change;
   logic                      send, event_hit, act;
   logic [COUNT_W-1:0]        miss_inc;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      neg_ang = -{in_ang_ff[ANGLE_W-1], in_ang_ff};
      if (neg_ang < 0) begin
         theta = ANGLE_W'(neg_ang + $signed(FULL_TURN));
      end else begin
         theta = ANGLE_W'(neg_ang);
      end

      dx  = {in_x_ff[COORD_W-1], in_x_ff} - {ref_x_ff[COORD_W-1], ref_x_ff};
      dy  = {in_y_ff[COORD_W-1], in_y_ff} - {ref_y_ff[COORD_W-1], ref_y_ff};
      dt  = $signed({1'b0, theta}) - $signed({1'b0, ref_theta_ff});
      adx = COORD_W'(dx < 0 ? -dx : dx);
      ady = COORD_W'(dy < 0 ? -dy : dy);
      adt = ANGLE_W'(dt < 0 ? -dt : dt);
      xs  = adx < xy_db_ff;
      ys  = ady < xy_db_ff;
      ts  = adt < ang_db_ff;

      ref_x_in     = ref_x_ff;
      ref_y_in     = ref_y_ff;
      ref_theta_in = ref_theta_ff;
      if (!in_off_ff) begin
         if (!xs) ref_x_in = in_x_ff;
         if (!ys) ref_y_in = in_y_ff;
         if (!ts) ref_theta_in = theta;
         same = xs && ys && ts;
      end else begin
         same = lifted_ff;
      end

      good_stamp_in = in_ok_ff ? in_now_ff : good_stamp_ff;
      pose_ok       = !in_off_ff && !in_x_ff[COORD_W-1] && !in_y_ff[COORD_W-1];
      hb            = (hb_period_ff > bc_period_ff) ? hb_period_ff : bc_period_ff;
      since_bcast   = in_now_ff - last_bcast_ff;
      since_change  = in_now_ff - last_change_ff;
      miss_inc      = (miss_ff < MISS_MAX) ? miss_ff + 1'b1 : miss_ff;

      send           = 1'b0;
      event_hit      = 1'b0;
      act            = 1'b0;
      lifted_in      = lifted_ff;
      idle_in        = idle_ff;
      miss_in        = miss_ff;
      last_change_in = last_change_ff;
      last_bcast_in  = last_bcast_ff;

      if (pose_ok) begin
         miss_in   = '0;
         event_hit = lifted_ff;
         lifted_in = 1'b0;
         if (!same || !idle_ff) begin
            if (!same) begin
               last_change_in = in_now_ff;
               idle_in        = 1'b0;
            end
            if (since_bcast >= TIME_W'(bc_period_ff)) begin
               send          = 1'b1;
               last_bcast_in = in_now_ff;
            end
            act = 1'b1;
            if (same && !stamped_ff && since_change >= TIME_W'(idle_delay_ff)) begin
               idle_in = 1'b1;
            end
         end else begin
            if (stamped_ff) idle_in = 1'b0;
            if (since_change >= TIME_W'(hb)) begin
               last_change_in = in_now_ff;
               send           = 1'b1;
            end
         end
      end else begin
         miss_in = miss_inc;
         if (miss_inc >= lost_limit_ff && !lifted_ff) begin
            lifted_in = 1'b1;
            event_hit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xy_db_ff      <= XY_DEADBAND_RST;
         ang_db_ff     <= ANGLE_DEADBAND_RST;
         hb_period_ff  <= HEARTBEAT_PERIOD_RST;
         idle_delay_ff <= IDLE_DELAY_RST;
         lost_limit_ff <= LOST_LIMIT_RST;
         bc_period_ff  <= BCAST_PERIOD_RST;
         stamped_ff    <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_XY_DEADBAND:      xy_db_ff      <= csr_wdata;
            CSR_ANGLE_DEADBAND:   ang_db_ff     <= csr_wdata;
            CSR_HEARTBEAT_PERIOD: hb_period_ff  <= csr_wdata;
            CSR_IDLE_DELAY:       idle_delay_ff <= csr_wdata;
            CSR_LOST_LIMIT:       lost_limit_ff <= csr_wdata[COUNT_W-1:0];
            CSR_BCAST_PERIOD:     bc_period_ff  <= csr_wdata;
            CSR_STAMPED_MODE:     stamped_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_x_ff   <= req_pos_x;
         in_y_ff   <= req_pos_y;
         in_ang_ff <= req_angle_cdeg;
         in_off_ff <= req_off_ground;
         in_ok_ff  <= req_decode_ok;
         in_now_ff <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_send_ff   <= send;
         out_event_ff  <= event_hit;
         out_lifted_ff <= lifted_in;
         out_act_ff    <= act;
         out_x_ff      <= in_x_ff;
         out_y_ff      <= in_y_ff;
         out_theta_ff  <= theta;
         out_stamp_ff  <= good_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff       <= '0;
         ref_y_ff       <= '0;
         ref_theta_ff   <= '0;
         lifted_ff      <= 1'b1;
         idle_ff        <= 1'b0;
         miss_ff        <= '0;
         last_change_ff <= '0;
         last_bcast_ff  <= '0;
         good_stamp_ff  <= '0;
      end else if (advance) begin
         ref_x_ff       <= ref_x_in;
         ref_y_ff       <= ref_y_in;
         ref_theta_ff   <= ref_theta_in;
         lifted_ff      <= lifted_in;
         idle_ff        <= idle_in;
         miss_ff        <= miss_in;
         last_change_ff <= last_change_in;
         last_bcast_ff  <= last_bcast_in;
         good_stamp_ff  <= good_stamp_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_send_pose    = out_send_ff;
   assign rsp_kidnap_event = out_event_ff;
   assign rsp_kidnap_now   = out_lifted_ff;
   assign rsp_activity     = out_act_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_out_theta    = out_theta_ff;
   assign rsp_out_stamp    = out_stamp_ff;

endmodule

`default_nettype wire
